// ===== design/riot_pkg.sv =====
// Package for the RAM-I/O-timer block: opcodes, register map, timer constants.
// Used by riot_ram_io_timer_top; depends on nothing.
package riot_pkg;

  // Scratch RAM geometry
  localparam int RAM_DEPTH = 128;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // Field widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 11;
  localparam int DATA_W  = 8;
  localparam int CYC_W   = 10;
  localparam int JOY_W   = 4;
  localparam int SW_W    = 5;
  localparam int TIMER_W = 18;

  // Opcodes (code 3 is unused and does nothing)
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Register select on address bits 2..0 outside RAM
  localparam logic [2:0] REG_PORT_A = 3'd0;
  localparam logic [2:0] REG_DIR_A  = 3'd1;
  localparam logic [2:0] REG_PORT_B = 3'd2;
  localparam logic [2:0] REG_DIR_B  = 3'd3;
  localparam logic [2:0] REG_INTIM  = 3'd4;
  localparam logic [2:0] REG_INSTAT = 3'd5;

  // Address decode bits
  localparam int ADDR_IO_BIT    = 9;
  localparam int ADDR_RAM_BIT   = 7;
  localparam int ADDR_TIMER_BIT = 4;

  // Timer constants
  localparam logic [TIMER_W-1:0] TIMER_RESET   = 18'd1024;
  localparam logic [1:0]         PRESCALE_RST  = 2'd3;
  localparam logic [DATA_W-1:0]  INSTAT_UNDER  = 8'hC0;

  // Prescale mode to shift: interval 1, 8, 64, 1024
  function automatic logic [3:0] interval_shift(input logic [1:0] mode);
    logic [3:0] sh;
    unique case (mode)
      2'd0:    sh = 4'd0;
      2'd1:    sh = 4'd3;
      2'd2:    sh = 4'd6;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

  // Address reaches scratch RAM
  function automatic logic is_ram(input logic [ADDR_W-1:0] a);
    return !a[ADDR_IO_BIT] && a[ADDR_RAM_BIT];
  endfunction

endpackage

// ===== design/riot_ram_io_timer_top.sv =====
// RAM-I/O-timer block: 128-byte scratch RAM, joystick/switch ports, interval timer.
// Uses riot_pkg for opcodes, register map and timer constants.
// Timing: an accepted item and its RAM read are registered; the result is registered
//   in the output register when the item retires, which waits while a held result
//   stalls the output. A new item is taken only after the one in flight has retired.
// Reset: control, timer and direction registers return to their reset values;
//   RAM entries read as zero via per-entry valid bits, all cleared at reset.
module riot_ram_io_timer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [riot_pkg::OP_W-1:0]     opcode,
  input  logic [riot_pkg::ADDR_W-1:0]   address,
  input  logic [riot_pkg::DATA_W-1:0]   write_data,
  input  logic [riot_pkg::CYC_W-1:0]    tick_cycles,
  input  logic [riot_pkg::JOY_W-1:0]    joystick_a,
  input  logic [riot_pkg::JOY_W-1:0]    joystick_b,
  input  logic [riot_pkg::SW_W-1:0]     console_switches,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [riot_pkg::DATA_W-1:0]   read_data
);

  // Scratch RAM and its per-entry valid bits
  logic [riot_pkg::DATA_W-1:0]    ram [riot_pkg::RAM_DEPTH];
  logic [riot_pkg::RAM_DEPTH-1:0] ram_vld;
  logic [riot_pkg::DATA_W-1:0]    ram_q;
  logic                           ram_vld_q;

  // Item held while RAM data comes back
  logic                           item_valid;
  logic [riot_pkg::OP_W-1:0]      item_op;
  logic [riot_pkg::ADDR_W-1:0]    item_addr;
  logic [riot_pkg::DATA_W-1:0]    item_data;
  logic [riot_pkg::CYC_W-1:0]     item_cycles;
  logic [riot_pkg::JOY_W-1:0]     item_joy_a;
  logic [riot_pkg::JOY_W-1:0]     item_joy_b;
  logic [riot_pkg::SW_W-1:0]      item_sw;

  // Architectural registers
  logic [riot_pkg::DATA_W-1:0]    dir_a;
  logic [riot_pkg::DATA_W-1:0]    dir_b;
  logic [riot_pkg::TIMER_W-1:0]   timer_count;
  logic [1:0]                     prescale_mode;
  logic                           underflow_flag;

  logic [riot_pkg::DATA_W-1:0]    dir_a_next;
  logic [riot_pkg::DATA_W-1:0]    dir_b_next;
  logic [riot_pkg::TIMER_W-1:0]   timer_count_next;
  logic [1:0]                     prescale_mode_next;
  logic                           underflow_flag_next;
  logic [riot_pkg::DATA_W-1:0]    result;

  logic                           accept;
  logic                           drain;
  logic                           item_is_ram;
  logic                           ram_we;
  logic [riot_pkg::RAM_AW-1:0]    rd_idx;
  logic [riot_pkg::RAM_AW-1:0]    wr_idx;
  logic [riot_pkg::TIMER_W-1:0]   intim_full;
  logic [riot_pkg::TIMER_W-1:0]   cyc_ext;

  // Handshake: one item in flight; it retires when the output register frees
  assign in_stall = item_valid;
  assign accept   = in_valid && !in_stall;
  assign drain    = item_valid && (!out_valid || !out_stall);

  assign rd_idx      = address[riot_pkg::RAM_AW-1:0];
  assign wr_idx      = item_addr[riot_pkg::RAM_AW-1:0];
  assign item_is_ram = riot_pkg::is_ram(item_addr);
  assign ram_we      = drain && (item_op == riot_pkg::OP_WRITE) && item_is_ram;

  // RAM array: write at retire, read at accept
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram[wr_idx] <= item_data;
    end
    if (accept) begin
      ram_q     <= ram[rd_idx];
      ram_vld_q <= ram_vld[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_vld <= '0;
    end else if (ram_we) begin
      ram_vld[wr_idx] <= 1'b1;
    end
  end

  // Capture item and live port levels
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (drain) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op     <= opcode;
      item_addr   <= address;
      item_data   <= write_data;
      item_cycles <= tick_cycles;
      item_joy_a  <= joystick_a;
      item_joy_b  <= joystick_b;
      item_sw     <= console_switches;
    end
  end

  // INTIM value: count scaled down by the interval
  always_comb begin
    unique case (prescale_mode)
      2'd0:    intim_full = timer_count;
      2'd1:    intim_full = timer_count >> 3;
      2'd2:    intim_full = timer_count >> 6;
      default: intim_full = timer_count >> 10;
    endcase
  end

  assign cyc_ext = {{(riot_pkg::TIMER_W - riot_pkg::CYC_W){1'b0}}, item_cycles};

  // Read-modify-write of the item's state; the unused opcode changes nothing
  always_comb begin
    dir_a_next          = dir_a;
    dir_b_next          = dir_b;
    timer_count_next    = timer_count;
    prescale_mode_next  = prescale_mode;
    underflow_flag_next = underflow_flag;
    result              = '0;
    unique case (item_op)
      riot_pkg::OP_READ: begin
        if (item_is_ram) begin
          result = ram_vld_q ? ram_q : '0;
        end else begin
          unique case (item_addr[2:0])
            riot_pkg::REG_PORT_A: result = ~{item_joy_a, item_joy_b};
            riot_pkg::REG_DIR_A:  result = dir_a;
            riot_pkg::REG_PORT_B: result = {~item_sw[4], ~item_sw[3], 2'b11, item_sw[2],
                                            1'b1, ~item_sw[1], ~item_sw[0]};
            riot_pkg::REG_DIR_B:  result = dir_b;
            riot_pkg::REG_INTIM: begin
              result              = intim_full[riot_pkg::DATA_W-1:0];
              underflow_flag_next = 1'b0;
            end
            riot_pkg::REG_INSTAT: result = underflow_flag ? riot_pkg::INSTAT_UNDER : '0;
            default:              result = '0;
          endcase
        end
      end
      riot_pkg::OP_WRITE: begin
        if (!item_is_ram) begin
          if (item_addr[riot_pkg::ADDR_TIMER_BIT]) begin
            prescale_mode_next  = item_addr[1:0];
            timer_count_next    = {{(riot_pkg::TIMER_W - riot_pkg::DATA_W){1'b0}}, item_data}
                                  << riot_pkg::interval_shift(item_addr[1:0]);
            underflow_flag_next = 1'b0;
          end else if (item_addr[2:0] == riot_pkg::REG_DIR_A) begin
            dir_a_next = item_data;
          end else if (item_addr[2:0] == riot_pkg::REG_DIR_B) begin
            dir_b_next = item_data;
          end
        end
      end
      riot_pkg::OP_TICK: begin
        // Count down; stop at zero and flag underflow
        if (timer_count != '0) begin
          if (cyc_ext >= timer_count) begin
            timer_count_next    = '0;
            underflow_flag_next = 1'b1;
          end else begin
            timer_count_next = timer_count - cyc_ext;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers commit when the item retires
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_a          <= '0;
      dir_b          <= '0;
      timer_count    <= riot_pkg::TIMER_RESET;
      prescale_mode  <= riot_pkg::PRESCALE_RST;
      underflow_flag <= 1'b0;
    end else if (drain) begin
      dir_a          <= dir_a_next;
      dir_b          <= dir_b_next;
      timer_count    <= timer_count_next;
      prescale_mode  <= prescale_mode_next;
      underflow_flag <= underflow_flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      read_data <= result;
    end
  end

  // Checks
  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    accept |=> item_valid)
    else $error("accepted item not held");

  a_out_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(item_valid))
    else $error("result appeared without an item");

  a_flag_count_zero: assert property (@(posedge clk) disable iff (rst)
    underflow_flag |-> (timer_count == '0))
    else $error("underflow flagged with nonzero count");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    (drain && (item_op != riot_pkg::OP_READ)) |=> (read_data == '0))
    else $error("write or tick returned nonzero data");

endmodule

// ===== verif/riot_checker.sv =====
`timescale 1ns / 100ps
// Checker for riot_ram_io_timer_top: watches the bus-item and read-data channels,
// keeps a shadow of the scratch RAM, direction registers and interval timer,
// and compares every result in order. Depends on riot_pkg.
module riot_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [riot_pkg::OP_W-1:0]   opcode,
  input  logic [riot_pkg::ADDR_W-1:0] address,
  input  logic [riot_pkg::DATA_W-1:0] write_data,
  input  logic [riot_pkg::CYC_W-1:0]  tick_cycles,
  input  logic [riot_pkg::JOY_W-1:0]  joystick_a,
  input  logic [riot_pkg::JOY_W-1:0]  joystick_b,
  input  logic [riot_pkg::SW_W-1:0]   console_switches,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [riot_pkg::DATA_W-1:0] read_data,
  output int                          fail_count,
  output int                          pending
);

  typedef logic [riot_pkg::OP_W-1:0]    op_t;
  typedef logic [riot_pkg::ADDR_W-1:0]  addr_t;
  typedef logic [riot_pkg::DATA_W-1:0]  data_t;
  typedef logic [riot_pkg::CYC_W-1:0]   cyc_t;
  typedef logic [riot_pkg::JOY_W-1:0]   joy_t;
  typedef logic [riot_pkg::SW_W-1:0]    sw_t;
  typedef logic [riot_pkg::TIMER_W-1:0] timer_t;

  // Shadow state of the block
  data_t      shadow_ram [riot_pkg::RAM_DEPTH];
  data_t      shadow_dir_a;
  data_t      shadow_dir_b;
  timer_t     shadow_timer;
  logic [1:0] shadow_mode;
  logic       shadow_uflow;

  // Read bytes still owed by the block, oldest first
  data_t read_data_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Prescale mode to interval shift: 1, 8, 64, 1024
  function automatic int mode_shift(input logic [1:0] mode);
    case (mode)
      2'd0:    return 0;
      2'd1:    return 3;
      2'd2:    return 6;
      default: return 10;
    endcase
  endfunction

  // Apply one bus item to the shadow state; returns the byte it reads back
  function automatic data_t apply_bus_item(
    input op_t   op,
    input addr_t a,
    input data_t d,
    input cyc_t  cyc,
    input joy_t  ja,
    input joy_t  jb,
    input sw_t   sw
  );
    data_t  rd;
    timer_t scaled;
    logic   ram_hit;
    rd = '0;
    ram_hit = !a[riot_pkg::ADDR_IO_BIT] && a[riot_pkg::ADDR_RAM_BIT];
    case (op)
      riot_pkg::OP_READ: begin
        if (ram_hit) begin
          rd = shadow_ram[a[riot_pkg::RAM_AW-1:0]];
        end else begin
          // outside RAM only bits 2..0 select, timer bit ignored on reads
          case (a[2:0])
            riot_pkg::REG_PORT_A: rd = ~{ja, jb};
            riot_pkg::REG_DIR_A:  rd = shadow_dir_a;
            riot_pkg::REG_PORT_B: begin
              rd = 8'hFF;
              rd[0] = !sw[0];
              rd[1] = !sw[1];
              rd[3] = sw[2];
              rd[6] = !sw[3];
              rd[7] = !sw[4];
            end
            riot_pkg::REG_DIR_B:  rd = shadow_dir_b;
            riot_pkg::REG_INTIM: begin
              scaled = shadow_timer >> mode_shift(shadow_mode);
              rd = scaled[riot_pkg::DATA_W-1:0];
              shadow_uflow = 1'b0;
            end
            riot_pkg::REG_INSTAT: rd = shadow_uflow ? riot_pkg::INSTAT_UNDER : '0;
            default:              rd = '0;
          endcase
        end
      end
      riot_pkg::OP_WRITE: begin
        if (ram_hit) begin
          shadow_ram[a[riot_pkg::RAM_AW-1:0]] = d;
        end else if (a[riot_pkg::ADDR_TIMER_BIT]) begin
          shadow_mode = a[1:0];
          shadow_timer = timer_t'(d) << mode_shift(a[1:0]);
          shadow_uflow = 1'b0;
        end else if (a[2:0] == riot_pkg::REG_DIR_A) begin
          shadow_dir_a = d;
        end else if (a[2:0] == riot_pkg::REG_DIR_B) begin
          shadow_dir_b = d;
        end
      end
      riot_pkg::OP_TICK: begin
        // a stopped timer stays stopped
        if (shadow_timer != '0) begin
          if (timer_t'(cyc) >= shadow_timer) begin
            shadow_timer = '0;
            shadow_uflow = 1'b1;
          end else begin
            shadow_timer = shadow_timer - timer_t'(cyc);
          end
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  // Watch both channels; each result comes later than the edge that took its item
  always @(posedge clk) begin
    data_t want;
    if (rst) begin
      for (int i = 0; i < riot_pkg::RAM_DEPTH; i++) shadow_ram[i] = '0;
      shadow_dir_a = '0;
      shadow_dir_b = '0;
      shadow_timer = riot_pkg::TIMER_RESET;
      shadow_mode  = riot_pkg::PRESCALE_RST;
      shadow_uflow = 1'b0;
      read_data_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (read_data_q.size() == 0) begin
          report_mismatch($sformatf("result read_data=%02h with none expected", read_data));
        end else begin
          want = read_data_q.pop_front();
          if (read_data !== want)
            report_mismatch($sformatf("read_data=%02h, expected %02h", read_data, want));
        end
      end
      if (in_valid && !in_stall)
        read_data_q.push_back(apply_bus_item(opcode, address, write_data, tick_cycles,
                                             joystick_a, joystick_b, console_switches));
    end
    pending = read_data_q.size();
  end

endmodule

// ===== verif/tb_riot_ram_io_timer_top.sv =====
`timescale 1ns / 100ps
// Testbench top for riot_ram_io_timer_top: directed and random bus items with
// random idling on both sides; checking is done by riot_checker. Depends on riot_pkg.
module tb_riot_ram_io_timer_top;

  typedef logic [riot_pkg::OP_W-1:0]   op_t;
  typedef logic [riot_pkg::ADDR_W-1:0] addr_t;
  typedef logic [riot_pkg::DATA_W-1:0] data_t;
  typedef logic [riot_pkg::CYC_W-1:0]  cyc_t;
  typedef logic [riot_pkg::JOY_W-1:0]  joy_t;
  typedef logic [riot_pkg::SW_W-1:0]   sw_t;

  localparam op_t OP_NOP = 2'd3;
  localparam int TOTAL_ITEMS = 1475;
  localparam int QUIET_TAIL  = 200;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  op_t   opcode;
  addr_t address;
  data_t write_data;
  cyc_t  tick_cycles;
  joy_t  joystick_a;
  joy_t  joystick_b;
  sw_t   console_switches;
  logic  out_valid;
  logic  out_stall;
  data_t read_data;

  int fail_count;
  int pending;
  int sent_count;
  bit quiet;

  riot_ram_io_timer_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .address          (address),
    .write_data       (write_data),
    .tick_cycles      (tick_cycles),
    .joystick_a       (joystick_a),
    .joystick_b       (joystick_b),
    .console_switches (console_switches),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_data        (read_data)
  );

  riot_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .address          (address),
    .write_data       (write_data),
    .tick_cycles      (tick_cycles),
    .joystick_a       (joystick_a),
    .joystick_b       (joystick_b),
    .console_switches (console_switches),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_data        (read_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive one item at the falling edge, hold it until the block takes it
  task automatic send_item(input op_t op, input addr_t a, input data_t d, input cyc_t c,
                           input joy_t ja, input joy_t jb, input sw_t sw);
    quiet = (sent_count >= TOTAL_ITEMS - QUIET_TAIL);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    opcode = op;
    address = a;
    write_data = d;
    tick_cycles = c;
    joystick_a = ja;
    joystick_b = jb;
    console_switches = sw;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    @(negedge clk);
  endtask

  // Same, with random joystick and switch levels
  task automatic send_op(input op_t op, input addr_t a, input data_t d, input cyc_t c);
    send_item(op, a, d, c, joy_t'($urandom), joy_t'($urandom), sw_t'($urandom));
  endtask

  function automatic addr_t ram_addr();
    addr_t a;
    a = addr_t'($urandom);
    a[riot_pkg::ADDR_IO_BIT] = 1'b0;
    a[riot_pkg::ADDR_RAM_BIT] = 1'b1;
    return a;
  endfunction

  // Any address outside the scratch RAM
  function automatic addr_t io_addr();
    addr_t a;
    a = addr_t'($urandom);
    if (!a[riot_pkg::ADDR_IO_BIT] && a[riot_pkg::ADDR_RAM_BIT]) begin
      if ($urandom_range(0, 1) == 0) a[riot_pkg::ADDR_IO_BIT] = 1'b1;
      else a[riot_pkg::ADDR_RAM_BIT] = 1'b0;
    end
    return a;
  endfunction

  function automatic cyc_t rand_cycles();
    if ($urandom_range(0, 3) == 0) return cyc_t'($urandom);
    return cyc_t'($urandom_range(0, 200));
  endfunction

  // Timer load followed by ticks and status polls
  task automatic run_timer_sequence();
    addr_t a;
    data_t load;
    int steps;
    a = io_addr();
    a[riot_pkg::ADDR_TIMER_BIT] = 1'b1;
    load = ($urandom_range(0, 3) == 0) ? data_t'($urandom) : data_t'($urandom_range(0, 40));
    send_op(riot_pkg::OP_WRITE, a, load, cyc_t'($urandom));
    steps = $urandom_range(3, 8);
    repeat (steps) begin
      if ($urandom_range(0, 2) == 0) begin
        a = io_addr();
        a[2:0] = ($urandom_range(0, 1) == 0) ? riot_pkg::REG_INTIM : riot_pkg::REG_INSTAT;
        send_op(riot_pkg::OP_READ, a, data_t'($urandom), cyc_t'($urandom));
      end else begin
        send_op(riot_pkg::OP_TICK, addr_t'($urandom), data_t'($urandom), rand_cycles());
      end
    end
  endtask

  // Single random item, weighted toward RAM and register traffic
  task automatic send_random_item();
    addr_t a;
    case ($urandom_range(0, 9))
      0, 1: send_op(riot_pkg::OP_WRITE, ram_addr(), data_t'($urandom), cyc_t'($urandom));
      2, 3: send_op(riot_pkg::OP_READ, ram_addr(), data_t'($urandom), cyc_t'($urandom));
      4, 5: send_op(riot_pkg::OP_READ, io_addr(), data_t'($urandom), cyc_t'($urandom));
      6: begin
        a = io_addr();
        a[riot_pkg::ADDR_TIMER_BIT] = 1'b0;
        send_op(riot_pkg::OP_WRITE, a, data_t'($urandom), cyc_t'($urandom));
      end
      7, 8: send_op(riot_pkg::OP_TICK, addr_t'($urandom), data_t'($urandom), rand_cycles());
      default: send_op(op_t'($urandom), addr_t'($urandom), data_t'($urandom),
                       cyc_t'($urandom));
    endcase
  endtask

  // Receiver: random stall bursts, one long hold-off, none at the tail
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    while (!quiet) begin
      if (!held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
    out_stall = 1'b0;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = riot_pkg::OP_READ;
    address = '0;
    write_data = '0;
    tick_cycles = '0;
    joystick_a = '0;
    joystick_b = '0;
    console_switches = '0;
    sent_count = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Port levels at their extremes
    send_item(riot_pkg::OP_READ, 11'h000, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h280, 8'hFF, 10'h3FF, 4'hF, 4'hF, 5'h1F);
    send_item(riot_pkg::OP_READ, 11'h002, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h7FA, 8'h00, 10'h000, 4'hF, 4'hF, 5'h1F);
    // Timer and status straight out of reset
    send_item(riot_pkg::OP_READ, 11'h004, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h005, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    // Direction registers, and a port data write that does nothing
    send_item(riot_pkg::OP_WRITE, 11'h281, 8'hFF, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_WRITE, 11'h003, 8'hA5, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_WRITE, 11'h000, 8'h3C, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h001, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h7FB, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    // RAM at both ends of its window, plus an entry never written
    send_item(riot_pkg::OP_WRITE, 11'h080, 8'hFF, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_WRITE, 11'h5FF, 8'h5A, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h480, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h0FF, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h0C3, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    // Underflow, then INTIM through an address with the timer bit set
    send_item(riot_pkg::OP_WRITE, 11'h014, 8'hFF, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_TICK, 11'h000, 8'h00, 10'h3FF, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h005, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h01C, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h005, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    // Zero load: tick on a stopped timer leaves the flag alone
    send_item(riot_pkg::OP_WRITE, 11'h015, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_TICK, 11'h000, 8'h00, 10'h005, 4'h0, 4'h0, 5'h00);
    // Unused opcode aimed at RAM, unmapped registers, largest loads
    send_item(OP_NOP, 11'h080, 8'h11, 10'h3FF, 4'hF, 4'hF, 5'h1F);
    send_item(riot_pkg::OP_READ, 11'h080, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h7FF, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_WRITE, 11'h216, 8'h80, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_WRITE, 11'h217, 8'hFF, 10'h000, 4'h0, 4'h0, 5'h00);
    send_item(riot_pkg::OP_READ, 11'h006, 8'h00, 10'h000, 4'h0, 4'h0, 5'h00);

    // Random traffic, with timer load/poll sequences mixed in
    while (sent_count < TOTAL_ITEMS) begin
      if ($urandom_range(0, 4) == 0) run_timer_sequence();
      else send_random_item();
    end
    in_valid = 1'b0;

    // Drain the last results, then let the bench settle before the verdict
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
